// ===== src/ird_pkg.sv =====
`default_nettype none

package ird_pkg;

	// frame and code geometry
	localparam int FRAME_EDGES = 32;
	localparam int CODE_BITS   = 16;

	localparam int TIME_W  = 32;
	localparam int CFG_W   = 32;
	localparam int CIDX_W  = 3;
	localparam int KEY_W   = 3;
	localparam int ADDR_W  = $clog2(FRAME_EDGES);
	localparam int EIDX_W  = $clog2(FRAME_EDGES + 1);
	localparam int POS_W   = $clog2(CODE_BITS + 1);
	localparam int BIT_W   = $clog2(CODE_BITS);
	// one store entry: inverted line level over the offset from burst start
	localparam int STORE_W = TIME_W + 1;

	// register reset values
	localparam logic [TIME_W-1:0]    GAP_LIMIT_RST     = TIME_W'(4000);
	localparam logic [TIME_W-1:0]    LEAD_IN_RST       = TIME_W'(27000);
	localparam logic [TIME_W-1:0]    BIT_THRESHOLD_RST = TIME_W'(1000);
	localparam logic [CODE_BITS-1:0] PATTERN_UP_RST    = CODE_BITS'(48960);
	localparam logic [CODE_BITS-1:0] PATTERN_DOWN_RST  = CODE_BITS'(58905);
	localparam logic [CODE_BITS-1:0] PATTERN_LEFT_RST  = CODE_BITS'(63495);
	localparam logic [CODE_BITS-1:0] PATTERN_RIGHT_RST = CODE_BITS'(62985);

	typedef enum logic [CIDX_W-1:0] {
		CFG_GAP_LIMIT     = 3'd0,
		CFG_LEAD_IN_TIME  = 3'd1,
		CFG_BIT_THRESHOLD = 3'd2,
		CFG_PATTERN_UP    = 3'd3,
		CFG_PATTERN_DOWN  = 3'd4,
		CFG_PATTERN_LEFT  = 3'd5,
		CFG_PATTERN_RIGHT = 3'd6
	} cfg_idx_t;

	typedef enum logic [KEY_W-1:0] {
		KEY_NONE  = 3'd0,
		KEY_UP    = 3'd1,
		KEY_DOWN  = 3'd2,
		KEY_LEFT  = 3'd3,
		KEY_RIGHT = 3'd4
	} key_t;

	typedef enum logic {
		TS_IDLE = 1'b0,
		TS_WALK = 1'b1
	} top_state_t;

	typedef enum logic [1:0] {
		WK_IDLE = 2'd0,
		WK_RUN  = 2'd1,
		WK_DONE = 2'd2
	} walk_state_t;

	// decode settings handed to the walker
	typedef struct packed {
		logic [TIME_W-1:0]    bit_threshold;
		logic [CODE_BITS-1:0] pattern_up;
		logic [CODE_BITS-1:0] pattern_down;
		logic [CODE_BITS-1:0] pattern_left;
		logic [CODE_BITS-1:0] pattern_right;
	} walk_cfg_t;

	// control from the front end to the walker
	typedef struct packed {
		logic start;
		logic ack;
	} walk_ctl_t;

	// walker result
	typedef struct packed {
		logic                 done;
		key_t                 key;
		logic [CODE_BITS-1:0] code;
	} walk_res_t;

endpackage

`default_nettype wire

// ===== src/ird_if.sv =====
`default_nettype none

// edge word channel
interface ird_edge_if
	import ird_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [TIME_W-1:0] edge_time;
	logic              edge_level;

	modport source (output valid, output edge_time, output edge_level, input ready);
	modport sink   (input valid, input edge_time, input edge_level, output ready);
endinterface

// key word channel
interface ird_key_if
	import ird_pkg::*;
();
	logic                 valid;
	logic                 ready;
	logic [KEY_W-1:0]     key_code;
	logic [CODE_BITS-1:0] code_word;

	modport source (output valid, output key_code, output code_word, input ready);
	modport sink   (input valid, input key_code, input code_word, output ready);
endinterface

`default_nettype wire

// ===== src/ird_ram.sv =====
`default_nettype none

module ird_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== src/ird_walk.sv =====
`default_nettype none

module ird_walk
	import ird_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire walk_cfg_t          cfg,
	input  wire walk_ctl_t          ctl,
	output      logic               rd_en,
	output      logic [ADDR_W-1:0]  rd_addr,
	input  wire logic [STORE_W-1:0] rd_data,
	output      walk_res_t          res
);

	walk_state_t          st_q, st_nxt;
	logic [EIDX_W-1:0]    rd_cnt_q;
	logic                 vld_s1;
	logic [ADDR_W-1:0]    idx_s1;
	logic [STORE_W-1:0]   prev_q;
	logic [POS_W-1:0]     pos_q;
	logic [CODE_BITS-1:0] decoded_q;
	logic [TIME_W-1:0]    span;
	logic                 bit_val;
	logic                 take_bit;
	logic                 last_entry;
	key_t                 key;

	// read stream: one entry a cycle while running
	assign rd_en   = (st_q == WK_RUN) && (rd_cnt_q < EIDX_W'(FRAME_EDGES));
	assign rd_addr = rd_cnt_q[ADDR_W-1:0];

	// bit from the interval between the previous entry and this one
	assign span       = rd_data[TIME_W-1:0] - prev_q[TIME_W-1:0];
	assign bit_val    = span > cfg.bit_threshold;
	assign take_bit   = vld_s1 && (idx_s1 != '0) && !prev_q[TIME_W]
		&& (pos_q < POS_W'(CODE_BITS));
	assign last_entry = vld_s1 && (idx_s1 == ADDR_W'(FRAME_EDGES - 1));

	// next state
	always_comb begin
		st_nxt = st_q;
		case (st_q)
			WK_IDLE: begin
				if (ctl.start) begin
					st_nxt = WK_RUN;
				end
			end
			WK_RUN: begin
				if (last_entry) begin
					st_nxt = WK_DONE;
				end
			end
			WK_DONE: begin
				if (ctl.ack) begin
					st_nxt = WK_IDLE;
				end
			end
			default: st_nxt = WK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= WK_IDLE;
		end else begin
			st_q <= st_nxt;
		end
	end

	// advance read counter and the read stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_cnt_q  <= '0;
			vld_s1    <= 1'b0;
			pos_q     <= '0;
			decoded_q <= '0;
		end else begin
			vld_s1 <= rd_en;
			if (st_q == WK_IDLE && ctl.start) begin
				rd_cnt_q <= '0;
				pos_q    <= '0;
			end else if (rd_en) begin
				rd_cnt_q <= rd_cnt_q + EIDX_W'(1);
			end
			if (take_bit) begin
				decoded_q[pos_q[BIT_W-1:0]] <= bit_val;
				pos_q <= pos_q + POS_W'(1);
			end
		end
	end

	// hold the read index and the previous entry
	always_ff @(posedge clk) begin
		if (rd_en) begin
			idx_s1 <= rd_addr;
		end
		if (vld_s1) begin
			prev_q <= rd_data;
		end
	end

	// match the code against the keys, up first
	always_comb begin
		if (decoded_q == cfg.pattern_up) begin
			key = KEY_UP;
		end else if (decoded_q == cfg.pattern_down) begin
			key = KEY_DOWN;
		end else if (decoded_q == cfg.pattern_left) begin
			key = KEY_LEFT;
		end else if (decoded_q == cfg.pattern_right) begin
			key = KEY_RIGHT;
		end else begin
			key = KEY_NONE;
		end
	end

	assign res.done = (st_q == WK_DONE);
	assign res.key  = key;
	assign res.code = decoded_q;

endmodule

`default_nettype wire

// ===== src/ir_remote_edge_decoder.sv =====
//  channel   dir  handshake     word
//  edge_in   in   valid/ready   edge_time[31:0], edge_level
//  key_out   out  valid/ready   key_code[2:0], code_word[15:0]
//  cfg       in   cfg_we only   cfg_index[2:0], cfg_wdata[31:0]
//
//  Outside a walk edge_in is always ready: back-to-back edges are taken every
//  cycle. The edge after a full store of 32 entries starts a walk over the
//  edge store through its single read port, one entry a cycle, with edge_in
//  held off until the key word is loaded. The key word waits in an output
//  register; a pending word only stalls the end of the next walk. Reset clears
//  burst state, the code and the registers to their defaults; the store is
//  not cleared.

`default_nettype none

module ir_remote_edge_decoder
	import ird_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	ird_edge_if.sink               edge_in,
	ird_key_if.source              key_out,
	input  wire logic              cfg_we,
	input  wire logic [CIDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]  cfg_wdata
);

	logic [TIME_W-1:0]    gap_limit_q;
	logic [TIME_W-1:0]    lead_in_q;
	logic [TIME_W-1:0]    bit_threshold_q;
	logic [CODE_BITS-1:0] pattern_up_q;
	logic [CODE_BITS-1:0] pattern_down_q;
	logic [CODE_BITS-1:0] pattern_left_q;
	logic [CODE_BITS-1:0] pattern_right_q;

	top_state_t           st_q, st_nxt;
	logic [TIME_W-1:0]    last_edge_q;
	logic [TIME_W-1:0]    burst_start_q;
	logic                 in_burst_q;
	logic [EIDX_W-1:0]    edge_index_q;

	logic                 out_valid_q;
	logic [KEY_W-1:0]     key_q;
	logic [CODE_BITS-1:0] code_q;

	logic                 accept;
	logic [TIME_W-1:0]    gap;
	logic                 in_gap;
	logic [TIME_W-1:0]    start_t;
	logic [TIME_W-1:0]    offset;
	logic                 past_lead;
	logic                 frame_full;
	logic                 out_free;
	logic                 load_out;

	logic                 mem_we;
	logic [STORE_W-1:0]   mem_wdata;
	logic                 mem_re;
	logic [ADDR_W-1:0]    mem_raddr;
	logic [STORE_W-1:0]   mem_rdata;

	walk_cfg_t            walk_cfg;
	walk_ctl_t            walk_ctl;
	walk_res_t            walk_res;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_limit_q     <= GAP_LIMIT_RST;
			lead_in_q       <= LEAD_IN_RST;
			bit_threshold_q <= BIT_THRESHOLD_RST;
			pattern_up_q    <= PATTERN_UP_RST;
			pattern_down_q  <= PATTERN_DOWN_RST;
			pattern_left_q  <= PATTERN_LEFT_RST;
			pattern_right_q <= PATTERN_RIGHT_RST;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_GAP_LIMIT:     gap_limit_q     <= cfg_wdata[TIME_W-1:0];
				CFG_LEAD_IN_TIME:  lead_in_q       <= cfg_wdata[TIME_W-1:0];
				CFG_BIT_THRESHOLD: bit_threshold_q <= cfg_wdata[TIME_W-1:0];
				CFG_PATTERN_UP:    pattern_up_q    <= cfg_wdata[CODE_BITS-1:0];
				CFG_PATTERN_DOWN:  pattern_down_q  <= cfg_wdata[CODE_BITS-1:0];
				CFG_PATTERN_LEFT:  pattern_left_q  <= cfg_wdata[CODE_BITS-1:0];
				CFG_PATTERN_RIGHT: pattern_right_q <= cfg_wdata[CODE_BITS-1:0];
				default: ;
			endcase
		end
	end

	// classify the incoming edge
	assign accept     = edge_in.valid && edge_in.ready;
	assign gap        = edge_in.edge_time - last_edge_q;
	assign in_gap     = gap <= gap_limit_q;
	assign start_t    = in_burst_q ? burst_start_q : edge_in.edge_time;
	assign offset     = edge_in.edge_time - start_t;
	assign past_lead  = offset > lead_in_q;
	assign frame_full = edge_index_q >= EIDX_W'(FRAME_EDGES);

	assign out_free = !out_valid_q || key_out.ready;
	assign load_out = (st_q == TS_WALK) && walk_res.done && out_free;

	// next state and walker control
	always_comb begin
		st_nxt         = st_q;
		walk_ctl.start = 1'b0;
		walk_ctl.ack   = 1'b0;
		edge_in.ready  = 1'b0;
		case (st_q)
			TS_IDLE: begin
				edge_in.ready = 1'b1;
				if (accept && in_gap && past_lead && frame_full) begin
					walk_ctl.start = 1'b1;
					st_nxt         = TS_WALK;
				end
			end
			TS_WALK: begin
				if (load_out) begin
					walk_ctl.ack = 1'b1;
					st_nxt       = TS_IDLE;
				end
			end
			default: st_nxt = TS_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= TS_IDLE;
		end else begin
			st_q <= st_nxt;
		end
	end

	// burst tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_edge_q   <= '0;
			burst_start_q <= '0;
			in_burst_q    <= 1'b0;
			edge_index_q  <= '0;
		end else if (accept) begin
			last_edge_q <= edge_in.edge_time;
			if (in_gap) begin
				in_burst_q    <= 1'b1;
				burst_start_q <= start_t;
				if (past_lead) begin
					if (frame_full) begin
						edge_index_q <= '0;
					end else begin
						edge_index_q <= edge_index_q + EIDX_W'(1);
					end
				end
			end else begin
				in_burst_q   <= 1'b0;
				edge_index_q <= '0;
			end
		end
	end

	// store the edge offset and inverted level
	assign mem_we    = accept && in_gap && past_lead && !frame_full;
	assign mem_wdata = {~edge_in.edge_level, offset};

	ird_ram #(
		.WIDTH(STORE_W),
		.DEPTH(FRAME_EDGES)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (edge_index_q[ADDR_W-1:0]),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	assign walk_cfg.bit_threshold = bit_threshold_q;
	assign walk_cfg.pattern_up    = pattern_up_q;
	assign walk_cfg.pattern_down  = pattern_down_q;
	assign walk_cfg.pattern_left  = pattern_left_q;
	assign walk_cfg.pattern_right = pattern_right_q;

	ird_walk u_walk (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (walk_cfg),
		.ctl     (walk_ctl),
		.rd_en   (mem_re),
		.rd_addr (mem_raddr),
		.rd_data (mem_rdata),
		.res     (walk_res)
	);

	// output register: hold the key word until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (key_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			key_q  <= walk_res.key;
			code_q <= walk_res.code;
		end
	end

	assign key_out.valid     = out_valid_q;
	assign key_out.key_code  = key_q;
	assign key_out.code_word = code_q;

`ifndef SYNTHESIS
	a_index_bound: assert property (@(posedge clk) disable iff (!arst_n)
		edge_index_q <= EIDX_W'(FRAME_EDGES))
		else $error("edge index past frame size");

	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> key_out.valid && st_q == TS_IDLE)
		else $error("finished walk did not produce a key word");

	a_key_range: assert property (@(posedge clk) disable iff (!arst_n)
		key_out.valid |-> key_out.key_code <= KEY_RIGHT)
		else $error("key code out of range");

	a_no_write_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		mem_re |-> !mem_we)
		else $error("store written during walk");
`endif

endmodule

`default_nettype wire

// ===== sim/tb_ir_remote_edge_decoder.sv =====
`timescale 1ns / 1ps

module tb_ir_remote_edge_decoder;
	import ird_pkg::*;

	localparam int SETTLE_CYCLES = 64;
	localparam int TAIL_CYCLES   = 100;
	localparam int HOLD_CYCLES   = 400;
	localparam int QUIET_LIMIT   = 3000;
	localparam int FRAME_WORDS   = FRAME_EDGES + 1;

	typedef struct packed {
		logic [TIME_W-1:0] stamp;
		logic              level;
	} edge_word_t;

	typedef struct packed {
		key_t                 key;
		logic [CODE_BITS-1:0] code;
	} key_word_t;

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic [CIDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]  cfg_wdata;

	ird_edge_if edge_bus ();
	ird_key_if  key_bus ();

	ir_remote_edge_decoder DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.edge_in   (edge_bus),
		.key_out   (key_bus),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// decoder settings as last written
	logic [TIME_W-1:0]    gap_max;
	logic [TIME_W-1:0]    lead_min;
	logic [TIME_W-1:0]    one_min;
	logic [CODE_BITS-1:0] pat_up;
	logic [CODE_BITS-1:0] pat_down;
	logic [CODE_BITS-1:0] pat_left;
	logic [CODE_BITS-1:0] pat_right;

	// burst tracking and edge store of the decode model
	logic [TIME_W-1:0]    prev_stamp;
	logic [TIME_W-1:0]    burst_t0;
	bit                   burst_open;
	int                   edges_held;
	logic [TIME_W-1:0]    edge_offs [FRAME_EDGES];
	logic                 edge_marks [FRAME_EDGES];
	logic [CODE_BITS-1:0] code_bits;

	edge_word_t  edges_to_send [$];
	key_word_t   keys_due [$];
	key_word_t   want;
	key_word_t   got;
	int          mismatches;
	int          quiet_cycles;

	// stimulus pacing
	bit          idling_on;
	int          send_gap;
	int          take_gap;
	int          hold_left;
	int          holds_asked;
	int          holds_done;
	logic [TIME_W-1:0] gen_t;
	bit          chain_ok;

	// advance the decode model by one edge word; return 1 when a key word results
	function automatic bit decode_edge(input logic [TIME_W-1:0] stamp, input logic level,
			output key_word_t word);
		logic [TIME_W-1:0] delta;
		logic [TIME_W-1:0] offset;
		logic [TIME_W-1:0] span;
		int pos;
		int i;
		bit made;
		made = 1'b0;
		word.key = KEY_NONE;
		word.code = '0;
		delta = stamp - prev_stamp;
		if (delta <= gap_max) begin
			if (!burst_open)
				burst_t0 = stamp;
			offset = stamp - burst_t0;
			if (offset > lead_min) begin
				if (edges_held >= FRAME_EDGES) begin
					// walk the store: each mark slot gives one code bit
					edges_held = 0;
					pos = 0;
					for (i = 0; i + 1 < FRAME_EDGES; i++) begin
						if (edge_marks[i] && pos < CODE_BITS) begin
							span = edge_offs[i + 1] - edge_offs[i];
							code_bits[pos] = (span > one_min);
							pos++;
						end
					end
					word.code = code_bits;
					if (code_bits == pat_up)
						word.key = KEY_UP;
					else if (code_bits == pat_down)
						word.key = KEY_DOWN;
					else if (code_bits == pat_left)
						word.key = KEY_LEFT;
					else if (code_bits == pat_right)
						word.key = KEY_RIGHT;
					made = 1'b1;
				end else begin
					edge_offs[edges_held] = offset;
					edge_marks[edges_held] = level;
					edges_held++;
				end
			end
			burst_open = 1'b1;
		end else begin
			burst_open = 1'b0;
			edges_held = 0;
		end
		prev_stamp = stamp;
		return made;
	endfunction

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// edge word sender
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edge_bus.valid <= 1'b0;
			edge_bus.edge_time <= '0;
			edge_bus.edge_level <= 1'b0;
			send_gap <= 0;
		end else if (!edge_bus.valid || edge_bus.ready) begin
			if (send_gap == 0 && edges_to_send.size() > 0) begin
				edge_bus.edge_time <= edges_to_send[0].stamp;
				edge_bus.edge_level <= edges_to_send[0].level;
				void'(edges_to_send.pop_front());
				edge_bus.valid <= 1'b1;
				if (idling_on && $urandom_range(0, 11) == 0)
					send_gap <= $urandom_range(1, 16);
			end else begin
				edge_bus.valid <= 1'b0;
				if (send_gap > 0)
					send_gap <= send_gap - 1;
			end
		end
	end

	// key word receiver: random stalls plus the long hold-off on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_bus.ready <= 1'b0;
			take_gap <= 0;
			hold_left <= 0;
			holds_done <= 0;
		end else if (holds_done != holds_asked) begin
			holds_done <= holds_asked;
			hold_left <= HOLD_CYCLES;
			key_bus.ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			key_bus.ready <= 1'b0;
		end else if (take_gap > 0) begin
			take_gap <= take_gap - 1;
			key_bus.ready <= 1'b0;
		end else if (idling_on && $urandom_range(0, 5) == 0) begin
			take_gap <= $urandom_range(0, 15);
			key_bus.ready <= 1'b0;
		end else begin
			key_bus.ready <= 1'b1;
		end
	end

	// check key words, predict from edge words, watch for a hang
	always @(posedge clk) begin
		if (arst_n) begin
			if (key_bus.valid && key_bus.ready) begin
				if (keys_due.size() == 0) begin
					$display("%0t: unexpected key word: expected none, actual %0d %h",
						$time, key_bus.key_code, key_bus.code_word);
					mismatches++;
				end else begin
					want = keys_due.pop_front();
					if (key_bus.key_code !== want.key) begin
						$display("%0t: key_code mismatch: expected %0d, actual %0d",
							$time, want.key, key_bus.key_code);
						mismatches++;
					end
					if (key_bus.code_word !== want.code) begin
						$display("%0t: code_word mismatch: expected %h, actual %h",
							$time, want.code, key_bus.code_word);
						mismatches++;
					end
				end
			end
			if (edge_bus.valid && edge_bus.ready) begin
				if (decode_edge(edge_bus.edge_time, edge_bus.edge_level, got))
					keys_due.push_back(got);
			end
			if ((key_bus.valid && key_bus.ready) || (edge_bus.valid && edge_bus.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	task automatic add_edge(input logic [TIME_W-1:0] stamp, input logic level);
		edge_word_t w;
		w.stamp = stamp;
		w.level = level;
		edges_to_send.push_back(w);
		gen_t = stamp;
	endtask

	// wait until every word went in and every key word came out
	task automatic drain(input int settle);
		do
			@(negedge clk);
		while (edges_to_send.size() != 0 || edge_bus.valid || keys_due.size() != 0);
		repeat (settle) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		case (idx)
			CFG_GAP_LIMIT:     gap_max = val;
			CFG_LEAD_IN_TIME:  lead_min = val;
			CFG_BIT_THRESHOLD: one_min = val;
			CFG_PATTERN_UP:    pat_up = val[CODE_BITS-1:0];
			CFG_PATTERN_DOWN:  pat_down = val[CODE_BITS-1:0];
			CFG_PATTERN_LEFT:  pat_left = val[CODE_BITS-1:0];
			CFG_PATTERN_RIGHT: pat_right = val[CODE_BITS-1:0];
			default: ;
		endcase
	endtask

	// write all registers; junk in the upper pattern bits must be dropped
	task automatic set_regs(input logic [TIME_W-1:0] gap, input logic [TIME_W-1:0] lead,
			input logic [TIME_W-1:0] thresh, input logic [CODE_BITS-1:0] up,
			input logic [CODE_BITS-1:0] down, input logic [CODE_BITS-1:0] left,
			input logic [CODE_BITS-1:0] right);
		write_reg(CFG_GAP_LIMIT, gap);
		write_reg(CFG_LEAD_IN_TIME, lead);
		write_reg(CFG_BIT_THRESHOLD, thresh);
		write_reg(CFG_PATTERN_UP, {16'($urandom()), up});
		write_reg(CFG_PATTERN_DOWN, {16'($urandom()), down});
		write_reg(CFG_PATTERN_LEFT, {16'($urandom()), left});
		write_reg(CFG_PATTERN_RIGHT, {16'($urandom()), right});
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	function automatic logic [CODE_BITS-1:0] pick_code();
		case ($urandom_range(0, 5))
			0: return pat_up;
			1: return pat_down;
			2: return pat_left;
			3: return pat_right;
			default: return 16'($urandom());
		endcase
	endfunction

	// random edges; steps up to max_step
	task automatic send_noise(input int n, input logic [TIME_W-1:0] max_step);
		int k;
		for (k = 0; k < n; k++)
			add_edge(gen_t + $urandom_range(0, max_step), 1'($urandom_range(0, 1)));
	endtask

	// one frame: break, burst start, lead-in (when fresh), 32 stored edges, trigger edge.
	// cut stops it early; scramble gives random levels and spacing.
	task automatic send_frame(input logic [CODE_BITS-1:0] code, input bit fresh,
			input bit scramble, input int cut);
		logic [TIME_W-1:0] jump;
		logic [TIME_W-1:0] off;
		logic [TIME_W-1:0] step;
		logic              level;
		int k;
		if (fresh) begin
			jump = $urandom();
			if (jump <= gap_max)
				jump = gap_max + 1;
			add_edge(gen_t + jump, 1'($urandom_range(0, 1)));
			add_edge(gen_t + $urandom_range(0, gap_max), 1'($urandom_range(0, 1)));
			off = '0;
			forever begin
				step = $urandom_range((gap_max + 1) / 2, gap_max);
				if (off + step > lead_min)
					break;
				off += step;
				add_edge(gen_t + step, 1'($urandom_range(0, 1)));
			end
		end else begin
			step = $urandom_range(0, gap_max);
		end
		for (k = 0; k < cut && k < FRAME_WORDS; k++) begin
			if (k > 0)
				step = $urandom_range(0, gap_max);
			if (!scramble && k < FRAME_EDGES && k % 2 == 1)
				step = code[k / 2] ? $urandom_range(one_min + 1, gap_max)
					: $urandom_range(0, one_min);
			if (scramble || k == FRAME_EDGES)
				level = 1'($urandom_range(0, 1));
			else
				level = (k % 2 == 0);
			add_edge(gen_t + step, level);
		end
	endtask

	// mix of clean frames, chained frames, scrambled, cut short, and noise
	task automatic run_frames(input int n);
		int k;
		int pick;
		for (k = 0; k < n; k++) begin
			pick = $urandom_range(0, 9);
			if (pick == 0) begin
				send_frame('0, 1'b1, 1'b1, FRAME_WORDS);
				chain_ok = 1'b1;
			end else if (pick == 1) begin
				send_frame(pick_code(), 1'b1, 1'b0, $urandom_range(1, FRAME_EDGES));
				chain_ok = 1'b0;
			end else if (pick == 2) begin
				send_noise($urandom_range(3, 10), 2 * gap_max);
				chain_ok = 1'b0;
			end else if (pick == 3 && chain_ok) begin
				send_frame(pick_code(), 1'b0, 1'b0, FRAME_WORDS);
			end else begin
				send_frame(pick_code(), 1'b1, 1'b0, FRAME_WORDS);
				chain_ok = 1'b1;
			end
		end
	endtask

	initial begin
		logic [TIME_W-1:0]    gap;
		logic [CODE_BITS-1:0] pa;
		int i;
		int ph;

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		edge_bus.valid = 1'b0;
		edge_bus.edge_time = '0;
		edge_bus.edge_level = 1'b0;
		key_bus.ready = 1'b0;
		idling_on = 1'b1;
		holds_asked = 0;
		mismatches = 0;
		quiet_cycles = 0;
		gen_t = '0;
		chain_ok = 1'b0;

		// model state after reset
		gap_max = GAP_LIMIT_RST;
		lead_min = LEAD_IN_RST;
		one_min = BIT_THRESHOLD_RST;
		pat_up = PATTERN_UP_RST;
		pat_down = PATTERN_DOWN_RST;
		pat_left = PATTERN_LEFT_RST;
		pat_right = PATTERN_RIGHT_RST;
		prev_stamp = '0;
		burst_t0 = '0;
		burst_open = 1'b0;
		edges_held = 0;
		code_bits = '0;
		for (i = 0; i < FRAME_EDGES; i++) begin
			edge_offs[i] = '0;
			edge_marks[i] = 1'b0;
		end

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// first edge against time zero, gap exactly at and just past the limit,
		// wrap of the timestamp, equal stamps, lead-in boundary
		add_edge(32'd2500, 1'b1);
		add_edge(32'd6500, 1'b0);
		add_edge(32'd10501, 1'b1);
		add_edge(32'hFFFF_FFFF, 1'b0);
		add_edge(32'd3999, 1'b1);
		add_edge(32'd3999, 1'b0);
		add_edge(32'd7999, 1'b1);
		add_edge(32'd11999, 1'b0);
		add_edge(32'd15999, 1'b1);
		add_edge(32'd19999, 1'b0);
		add_edge(32'd23999, 1'b1);
		add_edge(32'd27999, 1'b0);
		add_edge(32'd30999, 1'b1);
		add_edge(32'd31000, 1'b1);
		add_edge(32'h8000_0000, 1'b1);
		add_edge(32'h7FFF_FFFF, 1'b0);
		drain(SETTLE_CYCLES);

		// default settings: every key, under a long receiver hold-off
		holds_asked++;
		send_frame(pat_up, 1'b1, 1'b0, FRAME_WORDS);
		send_frame(pat_down, 1'b0, 1'b0, FRAME_WORDS);
		send_frame(pat_left, 1'b1, 1'b0, FRAME_WORDS);
		send_frame(pat_right, 1'b1, 1'b0, FRAME_WORDS);
		chain_ok = 1'b1;
		drain(0);
		run_frames(4);
		drain(SETTLE_CYCLES);

		// all four patterns equal: up wins
		pa = 16'($urandom());
		set_regs(32'd5000, 32'd20000, 32'd1500, pa, pa, pa, pa);
		send_frame(pa, 1'b1, 1'b0, FRAME_WORDS);
		send_frame(pa, 1'b0, 1'b0, FRAME_WORDS);
		send_frame(16'($urandom()), 1'b1, 1'b0, FRAME_WORDS);
		drain(SETTLE_CYCLES);

		// down shares its pattern with left: down wins
		pa = 16'($urandom());
		set_regs(32'd6000, 32'd15000, 32'd2500, pa, ~pa, ~pa, pa ^ 16'h00FF);
		send_frame(~pa, 1'b1, 1'b0, FRAME_WORDS);
		send_frame(pa ^ 16'h00FF, 1'b1, 1'b0, FRAME_WORDS);
		send_frame(pa, 1'b0, 1'b0, FRAME_WORDS);
		drain(SETTLE_CYCLES);

		// zero threshold and zero lead-in
		set_regs(32'd3000, 32'd0, 32'd0, 16'($urandom()), 16'($urandom()),
			16'($urandom()), 16'($urandom()));
		send_frame(pat_left, 1'b1, 1'b0, FRAME_WORDS);
		chain_ok = 1'b1;
		run_frames(3);
		drain(SETTLE_CYCLES);

		// widest gap, top threshold: every edge stays in the burst, bits all zero
		set_regs(32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 16'h0000, 16'hFFFF,
			16'($urandom()), 16'($urandom()));
		send_noise(100, 32'hFFFF_FFFF);
		drain(SETTLE_CYCLES);

		// zero gap and top lead-in: nothing is ever stored
		set_regs(32'd0, 32'hFFFF_FFFF, 32'd0, 16'hFFFF, 16'h0000,
			16'hFFFF, 16'h0000);
		send_noise(60, 32'd1);
		drain(SETTLE_CYCLES);

		// random settings
		for (ph = 0; ph < 3; ph++) begin
			gap = $urandom_range(300, 60000);
			set_regs(gap, $urandom_range(0, 5 * gap), $urandom_range(0, gap - 1),
				16'($urandom()), 16'($urandom()), 16'($urandom()), 16'($urandom()));
			chain_ok = 1'b0;
			run_frames(2);
			drain(SETTLE_CYCLES);
		end

		// back to defaults, no idling on either side
		idling_on = 1'b0;
		set_regs(GAP_LIMIT_RST, LEAD_IN_RST, BIT_THRESHOLD_RST, PATTERN_UP_RST,
			PATTERN_DOWN_RST, PATTERN_LEFT_RST, PATTERN_RIGHT_RST);
		chain_ok = 1'b0;
		run_frames(3);
		drain(TAIL_CYCLES);

		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// ===== sim.f =====
src/ird_pkg.sv
src/ird_if.sv
src/ird_ram.sv
src/ird_walk.sv
src/ir_remote_edge_decoder.sv
sim/tb_ir_remote_edge_decoder.sv
